// ===== src/fsa_pkg.sv =====
// Package for the fire spread automaton: image geometry constants,
// request codes and the request and response structs.
// No dependencies.
`timescale 1ns / 1ps

package fsa_pkg;

  localparam int unsigned ImgWidth   = 64;
  localparam int unsigned ImgHeight  = 64;
  localparam int unsigned XW         = $clog2(ImgWidth);
  localparam int unsigned YW         = $clog2(ImgHeight);
  localparam int unsigned AddrW      = 12;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned TabW       = $clog2(TableDepth);
  localparam int unsigned ByteW      = 8;

  typedef enum logic [1:0] {
    REQ_WR_IMG = 2'd0,
    REQ_WR_TAB = 2'd1,
    REQ_SPREAD = 2'd2,
    REQ_RD_IMG = 2'd3
  } req_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [AddrW-1:0] cell_addr;
    logic [ByteW-1:0] write_value;
    logic [ByteW-1:0] seed;
  } fsa_req_t;

  typedef struct packed {
    logic [ByteW-1:0] read_value;
    logic [1:0]       done_kind;
  } fsa_rsp_t;

endpackage

// ===== src/fire_spread_automaton_unit.sv =====
// Top level of the fire spread automaton: image and random table memories,
// the spread sequencer and the response register.
// Depends on fsa_pkg.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake               Payload
//  request   in         in_valid_i/in_stall_o   in_req_i  (fsa_req_t)
//  response  out        out_valid_o/out_stall_i out_rsp_o (fsa_rsp_t)
//
// A write of an image cell or a table entry goes from acceptance to the finish
// state and then to the response register; a cell read passes the read wait state first.
// In a spread step the sequencer issues one pixel read per cycle
// through the single read port of the image memory, and the 4032 pixels of
// rows one to the last are visited in column order.
// Reset only clears control state; both memories hold garbage until loaded
// and need no clearing pass. One request is in flight at a time. A held
// response stalls the next response, never the memories.

module fire_spread_automaton_unit
  import fsa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  fsa_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output fsa_rsp_t out_rsp_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RDWAIT = 4'b0010,
    ST_SPREAD = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  localparam int unsigned Cells = ImgWidth * ImgHeight;
  localparam logic [XW-1:0] XLast = XW'(ImgWidth - 1);
  localparam logic [YW-1:0] YLast = YW'(ImgHeight - 1);

  state_e state_q, state_d;

  // Memories. Both have a registered read port and one write port.
  logic [ByteW-1:0] img_mem [Cells];
  logic [ByteW-1:0] tab_mem [TableDepth];
  logic [ByteW-1:0] img_rdata_q;
  logic [ByteW-1:0] tab_rdata_q;

  logic             img_we;
  logic [AddrW-1:0] img_waddr;
  logic [ByteW-1:0] img_wdata;
  logic [AddrW-1:0] img_raddr;
  logic             tab_we;
  logic [TabW-1:0]  tab_raddr;

  // Spread sequencer: issue pointer and the pixel whose data is arriving.
  logic            issue_active_q, issue_active_d;
  logic [XW-1:0]   ix_q, ix_d;
  logic [YW-1:0]   iy_q, iy_d;
  logic            s1_valid_q;
  logic [XW-1:0]   s1_x_q;
  logic [YW-1:0]   s1_y_q;
  logic [TabW-1:0] idx_q, idx_d;

  // Pending response and output register.
  logic [1:0]       res_kind_q, res_kind_d;
  logic [ByteW-1:0] res_value_q, res_value_d;
  logic             out_valid_q, out_valid_d;
  fsa_rsp_t         out_rsp_q, out_rsp_d;

  logic       in_acc;
  req_e       in_kind;
  logic       pix_nonzero;
  logic [XW-1:0] dest_x;
  logic       out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_kind     = req_e'(in_req_i.req_type);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // The pixel in stage one sees its own data and its table byte together.
  assign pix_nonzero = (img_rdata_q != '0);
  assign dest_x      = s1_x_q + XW'(1) - XW'(tab_rdata_q[1:0]);

  // The table index advances only past pixels that were nonzero, so the
  // read for the next pixel uses the index after the pixel now arriving.
  assign idx_d     = (s1_valid_q && pix_nonzero) ? idx_q + TabW'(2) : idx_q;
  assign tab_raddr = idx_d;

  assign img_raddr = (state_q == ST_IDLE) ? in_req_i.cell_addr : {iy_q, ix_q};

  always_comb begin
    img_we    = 1'b0;
    img_waddr = in_req_i.cell_addr;
    img_wdata = in_req_i.write_value;
    if (state_q == ST_IDLE) begin
      img_we = in_acc && (in_kind == REQ_WR_IMG);
    end else if (state_q == ST_SPREAD && s1_valid_q) begin
      img_we = 1'b1;
      if (pix_nonzero) begin
        img_waddr = {s1_y_q - YW'(1), dest_x};
        img_wdata = img_rdata_q - {3'b000, tab_rdata_q[0], 4'b0000};
      end else begin
        img_waddr = {s1_y_q - YW'(1), s1_x_q};
        img_wdata = '0;
      end
    end
  end

  assign tab_we = in_acc && (in_kind == REQ_WR_TAB) &&
                  (in_req_i.cell_addr[AddrW-1:TabW] == '0);

  always_ff @(posedge clk_i) begin
    if (img_we) begin
      img_mem[img_waddr] <= img_wdata;
    end
    img_rdata_q <= img_mem[img_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[in_req_i.cell_addr[TabW-1:0]] <= in_req_i.write_value;
    end
    tab_rdata_q <= tab_mem[tab_raddr];
  end

  always_comb begin
    state_d        = state_q;
    issue_active_d = issue_active_q;
    ix_d           = ix_q;
    iy_d           = iy_q;
    res_kind_d     = res_kind_q;
    res_value_d    = res_value_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_rsp_d      = out_rsp_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_kind_d  = in_req_i.req_type;
          res_value_d = '0;
          case (in_kind)
            REQ_RD_IMG: state_d = ST_RDWAIT;
            REQ_SPREAD: begin
              state_d        = ST_SPREAD;
              issue_active_d = 1'b1;
              ix_d           = '0;
              iy_d           = YW'(1);
            end
            default: state_d = ST_FINISH;
          endcase
        end
      end
      ST_RDWAIT: begin
        res_value_d = img_rdata_q;
        state_d     = ST_FINISH;
      end
      ST_SPREAD: begin
        if (issue_active_q) begin
          if (iy_q == YLast) begin
            iy_d = YW'(1);
            ix_d = ix_q + XW'(1);
            if (ix_q == XLast) begin
              issue_active_d = 1'b0;
            end
          end else begin
            iy_d = iy_q + YW'(1);
          end
        end else if (s1_valid_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_rsp_d.read_value = res_value_q;
          out_rsp_d.done_kind  = res_kind_q;
          state_d              = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      issue_active_q <= 1'b0;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      issue_active_q <= issue_active_d;
      s1_valid_q     <= (state_q == ST_SPREAD) && issue_active_q;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ix_q        <= ix_d;
    iy_q        <= iy_d;
    s1_x_q      <= ix_q;
    s1_y_q      <= iy_q;
    res_kind_q  <= res_kind_d;
    res_value_q <= res_value_d;
    out_rsp_q   <= out_rsp_d;
    if (state_q == ST_IDLE) begin
      idx_q <= in_req_i.seed;
    end else begin
      idx_q <= idx_d;
    end
  end

`ifndef SYNTHESIS
  // Pixel data only flows while a spread step runs.
  a_s1_in_spread: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> state_q == ST_SPREAD)
    else $error("pixel stage active outside a spread step");

  // The write of a pixel never hits the cell being read in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SPREAD) && s1_valid_q && issue_active_q |-> img_waddr != img_raddr)
    else $error("image read and write collide during a spread step");

  // A new response only appears from the finish state.
  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FINISH)
    else $error("response raised outside the finish state");

  // A held response is not overwritten by the next one.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_rsp_q))
    else $error("stalled response changed");
`endif

endmodule

// ===== verif/fire_spread_automaton_checker.sv =====
// Response checker for the fire spread automaton: keeps its own copy of the
// fire image and the random table, predicts one response per request and compares.
// Depends on fsa_pkg.
`timescale 1ns / 1ps

module fire_spread_automaton_checker
  import fsa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  fsa_req_t    in_req_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  fsa_rsp_t    out_rsp_i,
  output int unsigned error_count_o,
  output int unsigned rsp_count_o,
  output int unsigned open_count_o
);

  localparam int unsigned ImgCells = ImgWidth * ImgHeight;

  logic [ByteW-1:0] fire_img [ImgCells];
  logic [ByteW-1:0] rand_tab [TableDepth];
  fsa_rsp_t         rsp_q [$];
  int unsigned      errs = 0;

  // One spread pass in place; later pixels see the writes of earlier ones.
  function automatic void spread_image(input logic [ByteW-1:0] seed);
    logic [ByteW-1:0] idx;
    logic [ByteW-1:0] pix;
    logic [ByteW-1:0] r;
    int unsigned      dest;
    idx = seed;
    for (int unsigned col = 0; col < ImgWidth; col++) begin
      for (int unsigned row = 1; row < ImgHeight; row++) begin
        pix = fire_img[row * ImgWidth + col];
        if (pix == '0) begin
          fire_img[(row - 1) * ImgWidth + col] = '0;
        end else begin
          r    = rand_tab[idx];
          idx  = idx + 8'd2;
          dest = (col + ImgWidth + 1 - r[1:0]) % ImgWidth;
          fire_img[(row - 1) * ImgWidth + dest] = pix - {r[0], 4'b0000};
        end
      end
    end
  endfunction

  function automatic fsa_rsp_t apply_request(input fsa_req_t req);
    fsa_rsp_t rsp;
    rsp.read_value = '0;
    rsp.done_kind  = req.req_type;
    case (req_e'(req.req_type))
      REQ_WR_IMG: begin
        if (req.cell_addr < ImgCells) fire_img[req.cell_addr] = req.write_value;
      end
      REQ_WR_TAB: begin
        if (req.cell_addr < TableDepth) rand_tab[req.cell_addr] = req.write_value;
      end
      REQ_SPREAD: begin
        spread_image(req.seed);
      end
      default: begin
        if (req.cell_addr < ImgCells) rsp.read_value = fire_img[req.cell_addr];
      end
    endcase
    return rsp;
  endfunction

  always @(posedge clk_i) begin : check_proc
    fsa_rsp_t want;
    if (!rst_ni) begin
      error_count_o <= 0;
      rsp_count_o   <= 0;
      open_count_o  <= 0;
    end else begin
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        rsp_count_o <= rsp_count_o + 1;
        if (rsp_q.size() == 0) begin
          $error("response with no request waiting: read_value %0d, done_kind %0d",
                 out_rsp_i.read_value, out_rsp_i.done_kind);
          errs++;
        end else begin
          want = rsp_q.pop_front();
          if (out_rsp_i.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value,
                   out_rsp_i.read_value);
            errs++;
          end
          if (out_rsp_i.done_kind !== want.done_kind) begin
            $error("done_kind: expected %0d, got %0d", want.done_kind,
                   out_rsp_i.done_kind);
            errs++;
          end
        end
      end
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) begin
        rsp_q.push_back(apply_request(in_req_i));
      end
      error_count_o <= errs;
      open_count_o  <= rsp_q.size();
    end
  end

endmodule

// ===== verif/fire_spread_automaton_unit_tb.sv =====
// Testbench top for the fire spread automaton: clock, reset, request and
// response drivers, and the verdict. Depends on fsa_pkg, the block itself
// and fire_spread_automaton_checker.
`timescale 1ns / 1ps

module fire_spread_automaton_unit_tb;
  import fsa_pkg::*;

  // The limit sits well above the slowest legal run.
  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned RandItems  = 140;
  // Length of the one long receiver hold-off, in cycles.
  localparam int unsigned HoldCycles = 300;

  logic     clk   = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid;
  logic     in_stall;
  fsa_req_t in_req;
  logic     out_valid;
  logic     out_stall;
  fsa_rsp_t out_rsp;

  int unsigned error_count;
  int unsigned rsp_count;
  int unsigned open_count;
  int unsigned sent_count = 0;
  int unsigned cycles     = 0;

  // Set by the request side: ask the response side for one long hold-off,
  // and switch all random idling off for the last stretch of the run.
  bit long_hold_req = 1'b0;
  bit calm          = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fire_spread_automaton_unit uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  fire_spread_automaton_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_rsp_i    (out_rsp),
    .error_count_o(error_count),
    .rsp_count_o  (rsp_count),
    .open_count_o (open_count)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Pixel values for the image: many zeros so that dead cells spread, many
  // values below 16 so that the subtraction wraps, and the rest anything.
  function automatic logic [ByteW-1:0] fire_byte();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return '0;
    if (pick < 5) return ByteW'($urandom_range(1, 15));
    return ByteW'($urandom);
  endfunction

  // Offers one request and returns once it has been accepted. A random idle
  // burst may come first. Valid is only lowered for such a burst, so a
  // back-to-back request keeps valid high without a glitch in the same step.
  task automatic issue(input req_e kind, input logic [AddrW-1:0] addr,
                       input logic [ByteW-1:0] value, input logic [ByteW-1:0] seed);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{req_type: kind, cell_addr: addr, write_value: value, seed: seed};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // Response side. Stall comes in random bursts between free-running
  // stretches. Once, on request, it holds off for a long stretch
  // so that the held response backs up into the request channel. In the calm
  // part at the end it never stalls.
  initial begin : response_side
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    req_e                kind;
    logic [AddrW-1:0]    addr;
    logic [ByteW-1:0]    value;
    int unsigned         pick;

    in_valid <= 1'b0;
    in_req   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Both memories are undefined after reset, so nothing is read before it
    // has been written. First a write and read-back at both ends of the image.
    issue(REQ_WR_IMG, 12'd0, 8'hFF, 8'h00);
    issue(REQ_RD_IMG, 12'd0, 8'hAA, 8'hFF);
    issue(REQ_WR_IMG, 12'd4095, 8'h00, 8'hFF);
    issue(REQ_RD_IMG, 12'd4095, 8'h55, 8'h00);

    // Load the whole random table and the whole image: a spread step reads
    // every pixel below the top row and table entries from any seed.
    for (int unsigned i = 0; i < TableDepth; i++) begin
      issue(REQ_WR_TAB, AddrW'(i), ByteW'($urandom), ByteW'($urandom));
    end
    for (int unsigned i = 0; i < ImgWidth * ImgHeight; i++) begin
      issue(REQ_WR_IMG, AddrW'(i), fire_byte(), ByteW'($urandom));
    end

    // Table entries at both ends with extreme values; the all-ones entry both
    // subtracts and shifts two columns left.
    issue(REQ_WR_TAB, 12'd0, 8'hFF, 8'h00);
    issue(REQ_WR_TAB, 12'd255, 8'h00, 8'h00);
    issue(REQ_WR_TAB, 12'd1, 8'h02, 8'h00);
    // Table writes past the last entry must leave the table untouched; the
    // spread steps below would show any aliasing.
    issue(REQ_WR_TAB, 12'd256, 8'h00, 8'h00);
    issue(REQ_WR_TAB, 12'd4095, 8'h55, 8'h00);
    // Pixels that exercise the byte wrap and the column wrap at both edges.
    issue(REQ_WR_IMG, 12'd64, 8'h05, 8'h00);
    issue(REQ_WR_IMG, 12'd127, 8'h10, 8'h00);
    issue(REQ_WR_IMG, 12'd4032, 8'h00, 8'h00);
    issue(REQ_SPREAD, 12'd0, 8'h00, 8'h00);
    issue(REQ_RD_IMG, 12'd0, 8'h00, 8'h00);
    issue(REQ_RD_IMG, 12'd63, 8'h00, 8'h00);
    issue(REQ_RD_IMG, 12'd4031, 8'h00, 8'h00);
    // The top seed makes the table index wrap right away.
    issue(REQ_SPREAD, 12'hFFF, 8'hFF, 8'hFF);
    issue(REQ_RD_IMG, 12'd2048, 8'hFF, 8'hFF);
    issue(REQ_RD_IMG, 12'd4095, 8'h00, 8'h00);

    // Random part. Every cell is written by now, so reads may go anywhere.
    for (int unsigned i = 0; i < RandItems; i++) begin
      if (i == 30) long_hold_req = 1'b1;
      // Let the block drain completely once before carrying on. Valid drops
      // first so that the request already taken is not offered again.
      if (i == 70) begin
        in_valid <= 1'b0;
        wait (rsp_count == sent_count);
        @(posedge clk);
      end
      if (i == RandItems - 30) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        kind = REQ_SPREAD;
      end else if (pick < 30) begin
        kind = REQ_WR_IMG;
      end else if (pick < 48) begin
        kind = REQ_WR_TAB;
      end else begin
        kind = REQ_RD_IMG;
      end
      addr  = AddrW'($urandom_range(0, 4095));
      value = ByteW'($urandom);
      // Mostly real table entries, now and then an index past the end.
      if (kind == REQ_WR_TAB && $urandom_range(0, 9) != 0) begin
        addr = AddrW'($urandom_range(0, TableDepth - 1));
      end
      if (kind == REQ_WR_IMG) value = fire_byte();
      issue(kind, addr, value, ByteW'($urandom));
    end
    in_valid <= 1'b0;

    // Wait for every response, then a little longer to catch stray ones.
    wait (rsp_count == sent_count);
    repeat (20) @(posedge clk);
    if (error_count == 0 && open_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/fsa_pkg.sv
src/fire_spread_automaton_unit.sv
verif/fire_spread_automaton_checker.sv
verif/fire_spread_automaton_unit_tb.sv
